// ===== sv/plt_pkg.sv =====
// shared types, codes and width helpers for the positional list engine
package plt_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int POS_W = 7;
	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_READ = 3'd2,
		OP_LOCATE = 3'd3,
		OP_PRIOR = 3'd4,
		OP_NEXT = 3'd5,
		OP_CLEAR = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD = 3'd0,
		CMD_ROTATE = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_CLEAR = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

	// compare width wide enough for positions, counts and cell indexes
	function automatic int plt_cmp_w(input int depth);
		int cw;
		cw = $clog2(depth + 1);
		return ((cw > POS_W) ? cw : POS_W) + 1;
	endfunction

endpackage

// ===== sv/plt_cell.sv =====
// one list slot: holds a word and takes it from a neighbor, the key or zero
module plt_cell import plt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int INDEX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [WORD_WIDTH-1:0] key,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	output logic [WORD_WIDTH-1:0] word
);

	localparam int PW = plt_cmp_w(DEPTH);
	localparam logic [PW-1:0] IDX = PW'(INDEX);

	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] word_d;
	logic [PW-1:0] pos_w;

	assign pos_w = PW'(ctl.pos);

	always_comb begin
		word_d = word_q;
		case (ctl.cmd)
			CMD_ROTATE: word_d = right_word;
			CMD_INSERT: begin
				if (IDX >= pos_w) begin
					word_d = left_word;
				end else if (IDX == pos_w - PW'(1)) begin
					word_d = key;
				end
			end
			CMD_DELETE: begin
				if (IDX >= pos_w - PW'(1)) begin
					word_d = right_word;
				end
			end
			CMD_CLEAR: word_d = '0;
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_d;
		end
	end

	assign word = word_q;

endmodule

// ===== sv/plt_scan.sv =====
// head observer: watches the two front cells while the ring turns
module plt_scan import plt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  op_t                           op,
	input  logic [POS_W-1:0]              pos,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	input  logic [$clog2(DEPTH)-1:0]      k,
	input  logic [WORD_WIDTH-1:0]         key,
	input  logic [WORD_WIDTH-1:0]         head,
	input  logic [WORD_WIDTH-1:0]         second,
	output logic                          hit,
	output logic [WORD_WIDTH-1:0]         rv,
	output logic [POS_W-1:0]              found
);

	localparam int PW = plt_cmp_w(DEPTH);

	logic hit_q;
	logic [WORD_WIDTH-1:0] rv_q;
	logic [POS_W-1:0] found_q;
	logic [PW-1:0] k_w;
	logic [PW-1:0] n_w;
	logic [PW-1:0] pos_w;
	logic match;
	logic [WORD_WIDTH-1:0] match_rv;
	logic in_list;
	logic has_succ;

	assign k_w = PW'(k);
	assign n_w = PW'(count);
	assign pos_w = PW'(pos);
	assign in_list = k_w < n_w;
	assign has_succ = (k_w + PW'(1)) < n_w;

	always_comb begin
		match = 1'b0;
		match_rv = '0;
		case (op)
			OP_READ, OP_DELETE: begin
				match = k_w == pos_w - PW'(1);
				match_rv = head;
			end
			OP_LOCATE: begin
				match = (head == key) && in_list;
			end
			OP_PRIOR: begin
				match = (second == key) && has_succ;
				match_rv = head;
			end
			OP_NEXT: begin
				match = (head == key) && has_succ;
				match_rv = second;
			end
			default: match = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (start) begin
			hit_q <= 1'b0;
		end else if (step && !hit_q && match) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rv_q <= '0;
			found_q <= '0;
		end else if (step && !hit_q && match) begin
			rv_q <= match_rv;
			if (op == OP_LOCATE) begin
				found_q <= POS_W'(k_w + PW'(1));
			end
		end
	end

	assign hit = hit_q;
	assign rv = rv_q;
	assign found = found_q;

endmodule

// ===== sv/positional_list_engine.sv =====
// top level: ordered list kept in a ring of cells with a head observer
//
//  channel  | handshake                 | word
//  ---------+---------------------------+----------------------------------------------
//  item     | item_valid / item_stall   | operation, position, value
//  result   | result_valid / result_stall| status, result_value, found_position,
//           |                           | list_length, list_empty
//
// insert, clear, bad positions and unused codes: result offered the cycle after accept
// read, delete, locate, prior and next: the scan state turns the cell ring once past the
// head observer, then the finish state loads the result once the result register is free
// one item in flight; the next is taken once the result register is free
// or being drained; reset clears every cell and the length
module positional_list_engine import plt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [2:0]                 operation,
	input  logic [POS_W-1:0]           position,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  result_value,
	output logic [POS_W-1:0]           found_position,
	output logic [POS_W-1:0]           list_length,
	output logic                       list_empty
);

	localparam int PW = plt_cmp_w(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN = 3'b100
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q;
	op_t op_q;
	logic [POS_W-1:0] pos_q;
	logic [WORD_WIDTH-1:0] key_q;

	logic out_valid_q;
	status_t out_status_q;
	logic [WORD_WIDTH-1:0] out_rv_q;
	logic [POS_W-1:0] out_found_q;
	logic [CW-1:0] out_len_q;

	logic [WORD_WIDTH-1:0] words [DEPTH];
	logic [WORD_WIDTH-1:0] key_in;
	logic [63:0] value_ext;
	cell_ctl_t ctl;
	logic out_free;
	logic accept;
	op_t op_in;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] n_w;
	logic scan_start;
	logic scan_hit;
	logic [WORD_WIDTH-1:0] scan_rv;
	logic [POS_W-1:0] scan_found;
	logic last_step;
	logic fin_load;

	// immediate decision at accept
	logic imm_load;
	status_t imm_status;
	logic [CW-1:0] imm_len;
	logic go_scan;

	assign out_free = !out_valid_q || !result_stall;
	assign item_stall = !((state_q == S_IDLE) && out_free);
	assign accept = item_valid && !item_stall;
	assign op_in = op_t'(operation);
	assign value_ext = {{(64 - VALUE_W){value[VALUE_W-1]}}, value};
	assign key_in = value_ext[WORD_WIDTH-1:0];
	assign pos_w = PW'(position);
	assign n_w = PW'(count_q);
	assign last_step = (state_q == S_SCAN) && (PW'(k_q) == PW'(DEPTH - 1));
	assign fin_load = (state_q == S_FIN) && out_free;
	assign scan_start = accept && go_scan;

	always_comb begin
		imm_load = 1'b0;
		imm_status = ST_OK;
		imm_len = count_q;
		go_scan = 1'b0;
		ctl.cmd = CMD_HOLD;
		ctl.pos = position;
		if (state_q == S_SCAN) begin
			ctl.cmd = CMD_ROTATE;
		end else if (fin_load && (op_q == OP_DELETE)) begin
			ctl.cmd = CMD_DELETE;
			ctl.pos = pos_q;
		end else if (accept) begin
			case (op_in)
				OP_INSERT: begin
					imm_load = 1'b1;
					if (position == '0) begin
						imm_status = ST_BAD_POS;
					end else if (n_w >= PW'(DEPTH)) begin
						imm_status = ST_FULL;
					end else if (pos_w > n_w + PW'(1)) begin
						imm_status = ST_BAD_POS;
					end else begin
						ctl.cmd = CMD_INSERT;
						imm_len = count_q + CW'(1);
					end
				end
				OP_DELETE, OP_READ: begin
					if (position == '0 || pos_w > n_w) begin
						imm_load = 1'b1;
						imm_status = ST_BAD_POS;
					end else begin
						go_scan = 1'b1;
					end
				end
				OP_LOCATE, OP_PRIOR, OP_NEXT: go_scan = 1'b1;
				OP_CLEAR: begin
					imm_load = 1'b1;
					ctl.cmd = CMD_CLEAR;
					imm_len = '0;
				end
				default: imm_load = 1'b1;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = (ctl.cmd == CMD_ROTATE) ? words[0] : '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end
		plt_cell #(
			.DEPTH(DEPTH),
			.WORD_WIDTH(WORD_WIDTH),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.key(key_in),
			.left_word(left_w),
			.right_word(right_w),
			.word(words[i])
		);
	end

	plt_scan #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.start(scan_start),
		.step(state_q == S_SCAN),
		.op(op_q),
		.pos(pos_q),
		.count(count_q),
		.k(k_q),
		.key(key_q),
		.head(words[0]),
		.second(words[1]),
		.hit(scan_hit),
		.rv(scan_rv),
		.found(scan_found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q <= '0;
			op_q <= OP_INSERT;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= op_in;
						count_q <= imm_len;
						k_q <= '0;
						if (go_scan) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					k_q <= k_q + IW'(1);
					if (last_step) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == OP_DELETE) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((accept && imm_load) || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			key_q <= key_in;
		end
		if (accept && imm_load) begin
			out_status_q <= imm_status;
			out_rv_q <= '0;
			out_found_q <= '0;
			out_len_q <= imm_len;
		end else if (fin_load) begin
			if (op_q == OP_READ || op_q == OP_DELETE) begin
				out_status_q <= ST_OK;
			end else begin
				out_status_q <= scan_hit ? ST_OK : ST_NOT_FOUND;
			end
			out_rv_q <= scan_rv;
			out_found_q <= scan_found;
			out_len_q <= (op_q == OP_DELETE) ? count_q - CW'(1) : count_q;
		end
	end

	assign result_valid = out_valid_q;
	assign status = out_status_q;
	assign result_value = $signed(VALUE_W'(out_rv_q));
	assign found_position = out_found_q;
	assign list_length = POS_W'(out_len_q);
	assign list_empty = out_len_q == '0;

endmodule
